[rtl/csvt_pkg.sv]
// Shared types and character constants for the CSV field tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Quote tracking codes; the unused fourth code counts as outside
  localparam logic [1:0] QM_OUTSIDE = 2'd0;
  localparam logic [1:0] QM_INSIDE  = 2'd1;
  localparam logic [1:0] QM_QSEEN   = 2'd2;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One result item
  typedef struct packed {
    logic       data_valid;
    logic [7:0] field_byte;
    logic       field_end;
    logic       record_end;
    logic [7:0] active_delimiter;
  } result_t;

  // Up to two result items made from one input item
  typedef struct packed {
    logic [1:0]        n;
    result_t [1:0]     r;
  } result_pair_t;

endpackage

`default_nettype wire

[rtl/csv_field_tokenizer.sv]
// Top level of the streaming CSV field tokenizer.
`timescale 1ns / 1ps
`default_nettype none

// Streaming CSV tokenizer: one text byte per input item, result items carry
// unquoted field bytes with field-end and record-end marks and the delimiter
// in force. The parser decides each byte combinationally and pushes up to two
// result items into a four-entry output queue; in_ready stays high while the
// queue has room for two, so bytes that give at most one item stream at one
// per cycle while the output does not stall. A byte that gives two items (a
// held carriage return followed by content, or a field end followed by the
// end-of-text close) leaves the single-item output port as two items.
// Result items are registered in the queue. Write cfg_fixed_delimiter only
// while idle; zero selects automatic choice of comma, semicolon or bar.
module csv_field_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_data_valid,
  output logic [7:0]      out_field_byte,
  output logic            out_field_end,
  output logic            out_record_end,
  output logic [7:0]      out_active_delimiter,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_fixed_delimiter
);

  logic [7:0]              fixed_r;
  logic                    accept;
  logic                    room;
  csvt_pkg::result_pair_t  results;
  csvt_pkg::result_t       head;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // Hold the configured delimiter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_r <= 8'h00;
    end else if (cfg_we) begin
      fixed_r <= cfg_fixed_delimiter;
    end
  end

  csvt_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_byte         (in_byte),
    .in_end_of_text  (in_end_of_text),
    .fixed_delimiter (fixed_r),
    .results         (results)
  );

  csvt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (results),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  // Drive result fields from the queue head
  assign out_data_valid       = head.data_valid;
  assign out_field_byte       = head.field_byte;
  assign out_field_end        = head.field_end;
  assign out_record_end       = head.record_end;
  assign out_active_delimiter = head.active_delimiter;

endmodule

`default_nettype wire

[rtl/csvt_parse.sv]
// Byte parser: quote, delimiter and record state plus result generation.
`timescale 1ns / 1ps
`default_nettype none

module csvt_parse (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_end_of_text,
  input  wire logic [7:0]            fixed_delimiter,
  output csvt_pkg::result_pair_t     results
);

  logic [1:0] qm_r, qm_nxt;
  logic [7:0] lock_r, lock_nxt;
  logic       pend_r, pend_nxt;

  // Append a content byte
  function automatic csvt_pkg::result_pair_t put_data(csvt_pkg::result_pair_t s,
                                                      logic [7:0] b, logic [7:0] d);
    csvt_pkg::result_pair_t t;
    t = s;
    t.r[s.n[0]].data_valid       = 1'b1;
    t.r[s.n[0]].field_byte       = b;
    t.r[s.n[0]].field_end        = 1'b0;
    t.r[s.n[0]].record_end       = 1'b0;
    t.r[s.n[0]].active_delimiter = d;
    t.n = s.n + 2'd1;
    return t;
  endfunction

  // Close the field, merging into a preceding open data item
  function automatic csvt_pkg::result_pair_t put_end(csvt_pkg::result_pair_t s,
                                                     logic rec, logic [7:0] d);
    csvt_pkg::result_pair_t t;
    logic                   last;
    logic                   idx;
    t = s;
    last = (s.n == 2'd2);
    if (s.n != 2'd0 && s.r[last].data_valid && !s.r[last].field_end) begin
      idx = last;
    end else begin
      idx = s.n[0];
      t.r[idx].data_valid = 1'b0;
      t.r[idx].field_byte = 8'h00;
      t.n = s.n + 2'd1;
    end
    t.r[idx].field_end        = 1'b1;
    t.r[idx].record_end       = rec;
    t.r[idx].active_delimiter = d;
    return t;
  endfunction

  // Handle one byte against the current state
  always_comb begin
    csvt_pkg::result_pair_t s;
    logic                   rec_done;
    logic                   outside;
    logic                   early;
    logic [7:0]             cur;
    s        = '0;
    rec_done = 1'b0;
    outside  = 1'b0;
    early    = 1'b0;
    qm_nxt   = qm_r;
    lock_nxt = lock_r;
    pend_nxt = pend_r;
    cur      = (fixed_delimiter != 8'h00) ? fixed_delimiter : lock_r;

    // Resolve a held carriage return
    if (pend_r) begin
      pend_nxt = 1'b0;
      if (in_byte == csvt_pkg::CH_LF) begin
        s        = put_end(s, 1'b1, cur);
        lock_nxt = 8'h00;
        rec_done = 1'b1;
        early    = 1'b1;
      end else begin
        s = put_data(s, csvt_pkg::CH_CR, cur);
      end
    end

    // Quote tracking
    if (!early) begin
      case (qm_r)
        csvt_pkg::QM_QSEEN: begin
          if (in_byte == csvt_pkg::CH_QUOTE) begin
            s      = put_data(s, csvt_pkg::CH_QUOTE, cur);
            qm_nxt = csvt_pkg::QM_INSIDE;
          end else begin
            qm_nxt  = csvt_pkg::QM_OUTSIDE;
            outside = 1'b1;
          end
        end
        csvt_pkg::QM_INSIDE: begin
          if (in_byte == csvt_pkg::CH_QUOTE) begin
            qm_nxt = csvt_pkg::QM_QSEEN;
          end else begin
            s = put_data(s, in_byte, cur);
          end
        end
        default: begin
          qm_nxt  = csvt_pkg::QM_OUTSIDE;
          outside = 1'b1;
        end
      endcase
    end

    // Unquoted byte meanings
    if (outside) begin
      if (in_byte == csvt_pkg::CH_QUOTE) begin
        qm_nxt = csvt_pkg::QM_INSIDE;
      end else if (in_byte == csvt_pkg::CH_LF) begin
        s        = put_end(s, 1'b1, cur);
        lock_nxt = 8'h00;
        rec_done = 1'b1;
      end else if (in_byte == csvt_pkg::CH_CR) begin
        if (in_end_of_text) begin
          s = put_data(s, csvt_pkg::CH_CR, cur);
        end else begin
          pend_nxt = 1'b1;
        end
      end else if (cur != 8'h00) begin
        if (in_byte == cur) begin
          s = put_end(s, 1'b0, cur);
        end else begin
          s = put_data(s, in_byte, cur);
        end
      end else if (in_byte == csvt_pkg::CH_COMMA || in_byte == csvt_pkg::CH_SEMI ||
                   in_byte == csvt_pkg::CH_BAR) begin
        // Lock the first auto delimiter of the record
        lock_nxt = in_byte;
        cur      = in_byte;
        s        = put_end(s, 1'b0, cur);
      end else begin
        s = put_data(s, in_byte, cur);
      end
    end

    // Close out the text
    if (in_end_of_text) begin
      if (!rec_done) begin
        s = put_end(s, 1'b1, cur);
      end
      qm_nxt   = csvt_pkg::QM_OUTSIDE;
      pend_nxt = 1'b0;
      lock_nxt = 8'h00;
    end

    results = s;
  end

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r   <= csvt_pkg::QM_OUTSIDE;
      lock_r <= 8'h00;
      pend_r <= 1'b0;
    end else if (accept) begin
      qm_r   <= qm_nxt;
      lock_r <= lock_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/csvt_outq.sv]
// Result queue: up to two items in per cycle, one out per ready cycle.
`timescale 1ns / 1ps
`default_nettype none

module csvt_outq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire csvt_pkg::result_pair_t push_data,
  output logic                        room,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output csvt_pkg::result_t           out_data
);

  localparam int unsigned CW = csvt_pkg::QAW + 1;

  csvt_pkg::result_t          q_r [csvt_pkg::QDEPTH];
  logic [csvt_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [csvt_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [1:0]                 n_push;
  logic                       pop;
  logic [csvt_pkg::QAW-1:0]   wr_ptr_p1;

  assign n_push    = push ? push_data.n : 2'd0;
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + csvt_pkg::QAW'(1);
  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  // Need space for a full pair before taking an item
  assign room      = (count_r <= CW'(csvt_pkg::QDEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + csvt_pkg::QAW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + csvt_pkg::QAW'(pop);
  assign count_nxt  = count_r + CW'(n_push) - CW'(pop);

  // Store pushed items
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= push_data.r[0];
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_p1] <= push_data.r[1];
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the streaming CSV field tokenizer.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_data_valid;
  logic [7:0] out_field_byte;
  logic       out_field_end;
  logic       out_record_end;
  logic [7:0] out_active_delimiter;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_fixed_delimiter = 8'h00;

  // Text bytes waiting to be sent, and tokens still owed by the block
  text_item_t        text_q[$];
  csvt_pkg::result_t exp_tokens[$];
  csvt_pkg::result_t step_out[$];

  // Tokenizer state as seen by the checker
  logic [7:0] fixed_delim = 8'h00;
  logic [7:0] locked_delim = 8'h00;
  logic [1:0] qmode = csvt_pkg::QM_OUTSIDE;
  logic       held_cr = 1'b0;

  int n_fail = 0;
  int n_seen = 0;
  int n_added = 0;

  csv_field_tokenizer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .in_end_of_text      (in_end_of_text),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_valid      (out_data_valid),
    .out_field_byte      (out_field_byte),
    .out_field_end       (out_field_end),
    .out_record_end      (out_record_end),
    .out_active_delimiter(out_active_delimiter),
    .cfg_we              (cfg_we),
    .cfg_fixed_delimiter (cfg_fixed_delimiter)
  );

  always #5 clk = ~clk;

  // Delimiter in force: the fixed one wins over the auto-locked one
  function automatic logic [7:0] cur_delim();
    return (fixed_delim != 8'h00) ? fixed_delim : locked_delim;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    csvt_pkg::result_t r;
    r = '0;
    r.data_valid = 1'b1;
    r.field_byte = b;
    r.active_delimiter = cur_delim();
    step_out.insert(step_out.size(), r);
  endfunction

  // Close the field; fold the mark into a bare content token of this byte
  function automatic void close_field(input logic rec);
    csvt_pkg::result_t r;
    if (step_out.size() > 0 && step_out[step_out.size() - 1].data_valid
        && !step_out[step_out.size() - 1].field_end) begin
      r = step_out.pop_back();
    end else begin
      r = '0;
    end
    r.field_end = 1'b1;
    r.record_end = rec;
    r.active_delimiter = cur_delim();
    step_out.insert(step_out.size(), r);
  endfunction

  // Match against the delimiter; in auto mode lock the first candidate
  function automatic logic delim_hit(input logic [7:0] b);
    logic [7:0] d;
    d = cur_delim();
    if (d != 8'h00) return b == d;
    if (b == csvt_pkg::CH_COMMA || b == csvt_pkg::CH_SEMI || b == csvt_pkg::CH_BAR) begin
      locked_delim = b;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the tokenizer by one text byte and queue the tokens it owes
  function automatic void tokenize_byte(input logic [7:0] b, input logic eot);
    logic rec_done;
    logic outside;
    logic skip;
    rec_done = 1'b0;
    outside = 1'b0;
    skip = 1'b0;
    step_out.delete();
    if (held_cr) begin
      held_cr = 1'b0;
      if (b == csvt_pkg::CH_LF) begin
        close_field(1'b1);
        locked_delim = 8'h00;
        rec_done = 1'b1;
        skip = 1'b1;
      end else begin
        emit_byte(csvt_pkg::CH_CR);
      end
    end
    if (!skip) begin
      if (qmode == csvt_pkg::QM_QSEEN) begin
        if (b == csvt_pkg::CH_QUOTE) begin
          emit_byte(csvt_pkg::CH_QUOTE);
          qmode = csvt_pkg::QM_INSIDE;
        end else begin
          qmode = csvt_pkg::QM_OUTSIDE;
          outside = 1'b1;
        end
      end else if (qmode == csvt_pkg::QM_INSIDE) begin
        if (b == csvt_pkg::CH_QUOTE) qmode = csvt_pkg::QM_QSEEN;
        else emit_byte(b);
      end else begin
        qmode = csvt_pkg::QM_OUTSIDE;
        outside = 1'b1;
      end
      if (outside) begin
        if (b == csvt_pkg::CH_QUOTE) begin
          qmode = csvt_pkg::QM_INSIDE;
        end else if (b == csvt_pkg::CH_LF) begin
          close_field(1'b1);
          locked_delim = 8'h00;
          rec_done = 1'b1;
        end else if (b == csvt_pkg::CH_CR) begin
          if (eot) emit_byte(csvt_pkg::CH_CR);
          else held_cr = 1'b1;
        end else if (delim_hit(b)) begin
          close_field(1'b0);
        end else begin
          emit_byte(b);
        end
      end
    end
    // End of text: close what is open and drop all record state
    if (eot) begin
      if (!rec_done) close_field(1'b1);
      qmode = csvt_pkg::QM_OUTSIDE;
      held_cr = 1'b0;
      locked_delim = 8'h00;
    end
    foreach (step_out[k]) exp_tokens.insert(exp_tokens.size(), step_out[k]);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(input logic on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  // Sender: offer queued bytes, hold each until accepted
  int   send_gap = 0;
  int   send_burst = 0;
  logic send_idle = 1'b1;

  always @(posedge clk) begin : driver
    logic keep;
    text_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (send_burst == 0) begin
        send_burst = $urandom_range(50, 300);
        send_idle = ($urandom_range(0, 3) != 0);
      end else begin
        send_burst--;
      end
      keep = in_valid;
      if (in_valid && in_ready) begin
        tokenize_byte(in_byte, in_end_of_text);
        keep = 1'b0;
        send_gap = pick_gap(send_idle);
      end
      if (!keep) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (text_q.size() > 0) begin
          it = text_q.pop_front();
          in_byte <= it.ch;
          in_end_of_text <= it.eot;
          keep = 1'b1;
        end
      end
      in_valid <= keep;
    end
  end

  // Receiver: check each accepted token, stall at random
  int   recv_stall = 0;
  int   recv_burst = 0;
  logic recv_idle = 1'b1;
  logic held_off = 1'b0;

  always @(posedge clk) begin : monitor
    csvt_pkg::result_t want;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_seen++;
        if (exp_tokens.size() == 0) begin
          $error("unexpected item: data_valid %0b field_byte %02h field_end %0b record_end %0b",
                 out_data_valid, out_field_byte, out_field_end, out_record_end);
          n_fail++;
        end else begin
          want = exp_tokens.pop_front();
          if (out_data_valid !== want.data_valid) begin
            $error("data_valid: expected %0b, got %0b", want.data_valid, out_data_valid);
            n_fail++;
          end
          if (out_field_byte !== want.field_byte) begin
            $error("field_byte: expected %02h, got %02h", want.field_byte, out_field_byte);
            n_fail++;
          end
          if (out_field_end !== want.field_end) begin
            $error("field_end: expected %0b, got %0b", want.field_end, out_field_end);
            n_fail++;
          end
          if (out_record_end !== want.record_end) begin
            $error("record_end: expected %0b, got %0b", want.record_end, out_record_end);
            n_fail++;
          end
          if (out_active_delimiter !== want.active_delimiter) begin
            $error("active_delimiter: expected %02h, got %02h",
                   want.active_delimiter, out_active_delimiter);
            n_fail++;
          end
        end
      end
      if (recv_burst == 0) begin
        recv_burst = $urandom_range(50, 300);
        recv_idle = ($urandom_range(0, 3) != 0);
      end else begin
        recv_burst--;
      end
      // Hold off once for a long stretch so the block fills and backs up
      if (!held_off && n_seen >= 400) begin
        held_off = 1'b1;
        recv_stall = 300;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        recv_stall = pick_gap(recv_idle);
      end
      out_ready <= rdy;
    end
  end

  task automatic add_byte(input logic [7:0] ch, input logic eot);
    text_item_t it;
    it.ch = ch;
    it.eot = eot;
    text_q.insert(text_q.size(), it);
    n_added++;
  endtask

  task automatic add_str(input string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  // One record with random fields and content, sometimes cut by end of text
  task automatic make_record(input logic [7:0] fd);
    int nf;
    int len;
    int r;
    logic [7:0] sep;
    if (fd != 8'h00) begin
      sep = fd;
    end else begin
      case ($urandom_range(0, 2))
        0: sep = csvt_pkg::CH_COMMA;
        1: sep = csvt_pkg::CH_SEMI;
        default: sep = csvt_pkg::CH_BAR;
      endcase
    end
    nf = $urandom_range(1, 5);
    for (int k = 0; k < nf; k++) begin
      if (k > 0) add_byte(sep, 1'b0);
      case ($urandom_range(0, 5))
        0: ;
        1, 2: begin
          add_byte(csvt_pkg::CH_QUOTE, 1'b0);
          len = $urandom_range(0, 6);
          for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 7))
              0: begin
                add_byte(csvt_pkg::CH_QUOTE, 1'b0);
                add_byte(csvt_pkg::CH_QUOTE, 1'b0);
              end
              1: add_byte(sep, 1'b0);
              2: add_byte(csvt_pkg::CH_CR, 1'b0);
              3: add_byte(csvt_pkg::CH_LF, 1'b0);
              default: add_byte(rand_letter(), 1'b0);
            endcase
          end
          add_byte(csvt_pkg::CH_QUOTE, 1'b0);
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 9))
              0: add_byte(csvt_pkg::CH_COMMA, 1'b0);
              1: add_byte(csvt_pkg::CH_SEMI, 1'b0);
              2: add_byte(csvt_pkg::CH_BAR, 1'b0);
              3: add_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
              default: add_byte(rand_letter(), 1'b0);
            endcase
          end
        end
      endcase
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      add_byte(rand_letter(), 1'b1);
    end else begin
      if ($urandom_range(0, 1)) add_byte(csvt_pkg::CH_CR, 1'b0);
      add_byte(csvt_pkg::CH_LF, r == 1);
    end
  endtask

  // Raw bytes over the full range, sometimes ending the text
  task automatic make_noise();
    int len;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++)
      add_byte(8'($urandom_range(0, 255)), (k == len - 1) && ($urandom_range(0, 3) == 0));
  endtask

  // Wait until every byte is sent and every token received, then let it drain
  task automatic wait_idle();
    do @(negedge clk);
    while (text_q.size() != 0 || in_valid || exp_tokens.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_delim(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_fixed_delimiter <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fixed_delim = v;
  endtask

  initial begin
    logic [7:0] plan[$];
    int target;
    plan = '{8'h00, csvt_pkg::CH_COMMA, 8'hFF, csvt_pkg::CH_SEMI, csvt_pkg::CH_QUOTE, 8'h00,
             csvt_pkg::CH_BAR, csvt_pkg::CH_CR, 8'h01, csvt_pkg::CH_LF,
             8'($urandom_range(1, 255)), 8'h00};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[p]) begin
      wait_idle();
      write_delim(plan[p]);
      n_added = 0;
      if (p == 0) begin
        // Auto lock, quote in mid field, doubled quote, empty lines, held CR
        add_str("a;b|c\n");
        add_str("t\"q\"\"r\"s,");
        add_byte(csvt_pkg::CH_LF, 1'b0);
        add_byte(csvt_pkg::CH_CR, 1'b0);
        add_byte(csvt_pkg::CH_LF, 1'b0);
        add_byte(csvt_pkg::CH_LF, 1'b0);
        add_byte(csvt_pkg::CH_CR, 1'b0);
        add_str("x");
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(csvt_pkg::CH_CR, 1'b1);
        add_byte(csvt_pkg::CH_COMMA, 1'b0);
        add_byte(csvt_pkg::CH_QUOTE, 1'b1);
      end
      target = n_added + 140;
      while (n_added < target) begin
        if ($urandom_range(0, 7) == 0) make_noise();
        else make_record(plan[p]);
      end
    end
    wait_idle();
    repeat (20) @(posedge clk);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(2_000_000 * 10);
    $display("Test completed with failures");
    $finish;
  end

endmodule
